// File: rtl/dwpe_pkg.sv
// Shared types, widths and helpers for the dual wiper pot to encoder delta unit.
// Depends on nothing; every other file refers to it by scoped names.
package dwpe_pkg;

  localparam int unsigned ChanW    = 2;
  localparam int unsigned SampleW  = 12;
  localparam int unsigned EncW     = 2;
  localparam int unsigned DeltaW   = 7;
  // Blended angle in units of 2^-25 of a turn; never reaches 2^27.
  localparam int unsigned NumW     = 28;
  localparam int unsigned FracBits = 25;
  // Channel field can address at most this many pots.
  localparam int unsigned MaxChans = 4;

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [EncW-1:0]    enc_t;
  typedef logic [NumW-1:0]    angle_t;

  // What the tracking stage wants done with the current word.
  typedef struct packed {
    logic emit;   // a nonzero delta goes out
    logic store;  // the channel position takes the new tick count
  } track_ctl_t;

  // Channel to encoder id mapping.
  function automatic enc_t enc_map(chan_t ch);
    enc_t id;
    unique case (ch)
      2'd0:    id = 2'd1;
      2'd1:    id = 2'd3;
      2'd2:    id = 2'd2;
      default: id = 2'd0;
    endcase
    return id;
  endfunction

endpackage

// File: rtl/dwpe_if.sv
// Valid/ready channel interfaces for input samples and encoder deltas.
// Depends on dwpe_pkg for field widths.
interface dwpe_in_if;
  logic             valid;
  logic             ready;
  dwpe_pkg::chan_t   channel;
  dwpe_pkg::sample_t wiper_a;
  dwpe_pkg::sample_t wiper_b;
  logic             prime;

  modport source (output valid, channel, wiper_a, wiper_b, prime, input ready);
  modport sink   (input valid, channel, wiper_a, wiper_b, prime, output ready);
endinterface

interface dwpe_out_if;
  logic                               valid;
  logic                               ready;
  dwpe_pkg::enc_t                     encoder_number;
  logic signed [dwpe_pkg::DeltaW-1:0] delta;

  modport source (output valid, encoder_number, delta, input ready);
  modport sink   (input valid, encoder_number, delta, output ready);
endinterface

// File: rtl/dwpe_angle.sv
// Blend two quadrature wiper samples into an angle in units of 2^-25 of a turn.
// Combinational; depends on dwpe_pkg.
module dwpe_angle (
  input  dwpe_pkg::sample_t wiper_a_i,
  input  dwpe_pkg::sample_t wiper_b_i,
  output dwpe_pkg::angle_t  angle_o
);

  logic               b_hi, a_hi, a_lo;
  logic [13:0]        c_wide;
  logic [12:0]        c;
  logic [14:0]        aa_base, aa, bb;
  logic signed [15:0] span;
  logic signed [29:0] interp;
  logic signed [30:0] num;

  assign b_hi = wiper_b_i > dwpe_pkg::sample_t'(2048);
  assign a_hi = wiper_a_i > dwpe_pkg::sample_t'(2048);
  assign a_lo = wiper_a_i < dwpe_pkg::sample_t'(2048);

  assign c_wide = b_hi ? ((14'd4096 - 14'(wiper_b_i)) << 1) : (14'(wiper_b_i) << 1);
  assign c      = c_wide[12:0];

  assign aa_base = b_hi ? (15'd4096 - 15'(wiper_a_i)) : 15'(wiper_a_i);

  // Shift the flipped wiper into its half-turn segment.
  always_comb begin
    priority if (b_hi) begin
      aa = aa_base + 15'd2048;
    end else if (a_hi) begin
      aa = aa_base - 15'd2048;
    end else begin
      aa = aa_base + 15'd6144;
    end
  end

  assign bb = a_lo ? (15'd8192 - 15'(wiper_b_i)) : 15'(wiper_b_i);

  assign span   = $signed({1'b0, bb}) - $signed({1'b0, aa});
  assign interp = $signed({1'b0, c}) * span;
  assign num    = $signed({4'b0, aa, 12'b0}) + 31'(interp);

  // Clamp at zero.
  assign angle_o = num[30] ? '0 : num[dwpe_pkg::NumW-1:0];

endmodule

// File: rtl/dwpe_track.sv
// Scale the angle to ticks, wrap old minus new, and decide emit and store.
// Combinational; depends on dwpe_pkg.
module dwpe_track #(
  parameter int unsigned TICKS_PER_TURN = 64,
  parameter int unsigned PosW           = 7
) (
  input  dwpe_pkg::angle_t                   angle_i,
  input  logic [PosW-1:0]                    old_pos_i,
  input  logic                               prime_i,
  output logic [PosW-1:0]                    new_pos_o,
  output logic signed [dwpe_pkg::DeltaW-1:0] delta_o,
  output dwpe_pkg::track_ctl_t               ctl_o
);

  localparam int unsigned ProdW  = dwpe_pkg::NumW + PosW;
  localparam int          WrapHi = int'(TICKS_PER_TURN - TICKS_PER_TURN / 2);
  localparam int          WrapLo = int'(TICKS_PER_TURN / 2) - int'(TICKS_PER_TURN);

  logic [ProdW-1:0]   scaled;
  logic signed [PosW:0] diff, wrapped;

  assign scaled    = ProdW'(angle_i) * ProdW'(TICKS_PER_TURN);
  assign new_pos_o = scaled[dwpe_pkg::FracBits +: PosW];

  assign diff = $signed({1'b0, old_pos_i}) - $signed({1'b0, new_pos_o});

  // Fold the difference into the half-turn window.
  always_comb begin
    priority if (int'(diff) > WrapHi) begin
      wrapped = diff - (PosW+1)'(TICKS_PER_TURN);
    end else if (int'(diff) < WrapLo) begin
      wrapped = diff + (PosW+1)'(TICKS_PER_TURN);
    end else begin
      wrapped = diff;
    end
  end

  assign delta_o     = dwpe_pkg::DeltaW'(wrapped);
  assign ctl_o.emit  = !prime_i && (wrapped != '0);
  assign ctl_o.store = prime_i || ctl_o.emit;

endmodule

// File: rtl/dual_wiper_pot_to_encoder_delta_unit.sv
// Endless dual wiper potentiometer to encoder delta converter, top level.
// Depends on dwpe_pkg, dwpe_if, dwpe_angle and dwpe_track.
//
// Each input word holds a channel number, two 12-bit wiper samples and a
// prime flag. The wipers are blended into an angle, scaled to TICKS_PER_TURN
// ticks and compared with the last position stored for that channel. A prime
// word only stores the position. Otherwise the wrapped change (old minus new)
// goes out with the encoder id (channel 0 -> 1, 1 -> 3, 2 -> 2) when it is
// nonzero, and the position is updated; a zero change produces no output word.
// Channels at or above NUM_CHANNELS are dropped on acceptance. The block takes
// one word per cycle while no output word is stalled; an accepted word moves
// on in order: the input register feeds the angle interpolation multiply,
// whose result is registered, and that register feeds the tick scaling
// multiply and wrap, whose result lands in the output register.
// Positions live in flip-flops and are read and written in the last stage, so
// words for the same channel may follow each other in consecutive cycles.
// Each stage advances into a free slot, so while a word waits at the output
// two more words can still enter, and words that produce no output leave the
// pipe anyway.
module dual_wiper_pot_to_encoder_delta_unit #(
  parameter int unsigned TICKS_PER_TURN = 64,
  parameter int unsigned NUM_CHANNELS   = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  dwpe_in_if.sink    in_i,
  dwpe_out_if.source out_o
);

  // Position width holds 0..TICKS_PER_TURN inclusive.
  localparam int unsigned PosW     = $clog2(TICKS_PER_TURN + 1);
  localparam int unsigned PosDepth = (NUM_CHANNELS < dwpe_pkg::MaxChans) ?
                                     NUM_CHANNELS : dwpe_pkg::MaxChans;
  localparam int unsigned IdxW     = (PosDepth > 1) ? $clog2(PosDepth) : 1;

  // Stage 1: registered input word.
  logic              s1_v_q, s1_v_d;
  dwpe_pkg::chan_t   s1_ch_q;
  dwpe_pkg::sample_t s1_a_q, s1_b_q;
  logic              s1_prime_q;

  // Stage 2: blended angle.
  logic              s2_v_q, s2_v_d;
  dwpe_pkg::chan_t   s2_ch_q;
  logic              s2_prime_q;
  dwpe_pkg::angle_t  s2_angle_q;

  // Output register.
  logic                               out_v_q, out_v_d;
  dwpe_pkg::enc_t                     out_enc_q;
  logic signed [dwpe_pkg::DeltaW-1:0] out_delta_q;

  logic [PosW-1:0] pos_q [PosDepth];

  dwpe_pkg::angle_t                   angle;
  logic [PosW-1:0]                    old_pos, new_pos;
  logic signed [dwpe_pkg::DeltaW-1:0] delta;
  dwpe_pkg::track_ctl_t               ctl;

  logic in_accept, in_keep, out_load, s2_fire, s2_free, s1_move;

  // Handshake chain: each slot frees when its word moves on.
  assign out_load  = !out_v_q || out_o.ready;
  assign s2_fire   = s2_v_q && (!ctl.emit || out_load);
  assign s2_free   = !s2_v_q || s2_fire;
  assign s1_move   = s1_v_q && s2_free;
  assign in_i.ready = !s1_v_q || s2_free;
  assign in_accept = in_i.valid && in_i.ready;
  // Drop words for channels that do not exist.
  assign in_keep   = int'(in_i.channel) < int'(NUM_CHANNELS);

  dwpe_angle u_angle (
    .wiper_a_i (s1_a_q),
    .wiper_b_i (s1_b_q),
    .angle_o   (angle)
  );

  assign old_pos = pos_q[s2_ch_q[IdxW-1:0]];

  dwpe_track #(
    .TICKS_PER_TURN (TICKS_PER_TURN),
    .PosW           (PosW)
  ) u_track (
    .angle_i   (s2_angle_q),
    .old_pos_i (old_pos),
    .prime_i   (s2_prime_q),
    .new_pos_o (new_pos),
    .delta_o   (delta),
    .ctl_o     (ctl)
  );

  always_comb begin
    s1_v_d = in_i.ready ? (in_accept && in_keep) : s1_v_q;
    s2_v_d = s2_free ? s1_move : s2_v_q;
    out_v_d = out_load ? (s2_v_q && ctl.emit) : out_v_q;
  end

  // Valid bits and channel positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < int'(PosDepth); i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      if (s2_fire && ctl.store) begin
        pos_q[s2_ch_q[IdxW-1:0]] <= new_pos;
      end
    end
  end

  // Payload: load on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ch_q    <= in_i.channel;
      s1_a_q     <= in_i.wiper_a;
      s1_b_q     <= in_i.wiper_b;
      s1_prime_q <= in_i.prime;
    end
    if (s1_move) begin
      s2_ch_q    <= s1_ch_q;
      s2_prime_q <= s1_prime_q;
      s2_angle_q <= angle;
    end
    if (out_load && s2_v_q && ctl.emit) begin
      out_enc_q   <= dwpe_pkg::enc_map(s2_ch_q);
      out_delta_q <= delta;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.encoder_number = out_enc_q;
  assign out_o.delta          = out_delta_q;

endmodule

// File: rtl/dwpe_checker.sv
// Port-level assertions for the pot to encoder delta unit, bound to the top.
// Depends on dwpe_pkg and the top level's interface ports.
module dwpe_checker #(
  parameter int unsigned TICKS_PER_TURN = 64
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input dwpe_pkg::enc_t                     out_enc_i,
  input logic signed [dwpe_pkg::DeltaW-1:0] out_delta_i
);

  // Stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_delta_i) && $stable(out_enc_i))
    else $error("output word changed while stalled");

  // Input only stalls behind a stalled output word.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Emitted delta is nonzero and within half a turn plus one tick.
  a_delta_range: assert property (@(posedge clk_i)
    disable iff (!rst_ni || TICKS_PER_TURN > 64)
    out_valid_i |-> out_delta_i != '0 &&
      int'(out_delta_i) <= int'(TICKS_PER_TURN / 2) + 1 &&
      int'(out_delta_i) >= -int'(TICKS_PER_TURN / 2) - 1)
    else $error("delta out of range or zero");

  // Input side stays live in the cycle after reset.
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_i || in_valid_i)
    else $error("input not ready after reset");

endmodule

bind dual_wiper_pot_to_encoder_delta_unit dwpe_checker #(
  .TICKS_PER_TURN (TICKS_PER_TURN)
) u_dwpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_enc_i   (out_o.encoder_number),
  .out_delta_i (out_o.delta)
);

// File: dv/dual_wiper_pot_to_encoder_delta_unit_tb.sv
// Self-checking testbench for the dual wiper pot to encoder delta unit.
// Depends on dwpe_pkg, the dwpe_in_if/dwpe_out_if interfaces and the unit's RTL.
module dual_wiper_pot_to_encoder_delta_unit_tb;

  localparam int unsigned TICKS_PER_TURN = 64;
  localparam int unsigned NUM_CHANNELS   = 3;
  localparam int unsigned RandomWords    = 300;  // tracked words per idling phase

  // Encoder id for each channel number; channel three only exists in wider builds.
  localparam dwpe_pkg::enc_t EncOfChan [dwpe_pkg::MaxChans] = '{2'd1, 2'd3, 2'd2, 2'd0};

  typedef struct packed {
    dwpe_pkg::enc_t enc;
    logic [6:0]     delta;
  } delta_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dwpe_in_if  in_if ();
  dwpe_out_if out_if ();

  dual_wiper_pot_to_encoder_delta_unit #(
    .TICKS_PER_TURN(TICKS_PER_TURN),
    .NUM_CHANNELS  (NUM_CHANNELS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk = ~clk;

  // Predictor state: last tick position per channel, and the deltas still owed.
  logic [6:0]  pot_ticks [dwpe_pkg::MaxChans];
  delta_word_t expected_deltas[$];

  // Idling controls, in percent of cycles; changed between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned words_sent  = 0;
  int unsigned deltas_seen = 0;
  int unsigned mismatches  = 0;

  // Blend the two quadrature wipers into a tick count. Samples are 1/4096
  // fractions; after the flips and shifts aa and bb are in units of 1/8192,
  // and the interpolated angle num is in units of 2^-25 of a turn.
  function automatic longint wiper_angle_ticks(dwpe_pkg::sample_t a, dwpe_pkg::sample_t b);
    longint av, bv, c, aa, bb, num;
    av = a;
    bv = b;
    c  = (bv > 2048) ? 2 * (4096 - bv) : 2 * bv;
    aa = (bv > 2048) ? 4096 - av : av;
    bb = (av < 2048) ? 4096 - bv : bv;
    // The midpoint sample 2048 falls through to the +6144 shift.
    if (bv > 2048)
      aa += 2048;
    else if (av > 2048)
      aa -= 2048;
    else
      aa += 6144;
    if (av < 2048)
      bb += 4096;
    num = aa * 4096 + c * (bb - aa);
    if (num < 0)
      num = 0;
    return (num * TICKS_PER_TURN) >>> dwpe_pkg::FracBits;
  endfunction

  // Track one accepted word: store on prime, otherwise owe a delta if the
  // wrapped change is nonzero. Out-of-range channels leave no trace.
  function automatic void track_word(dwpe_pkg::chan_t ch, dwpe_pkg::sample_t a,
                                     dwpe_pkg::sample_t b, logic prm);
    longint      n, d;
    delta_word_t w;
    if (ch >= NUM_CHANNELS)
      return;
    n = wiper_angle_ticks(a, b);
    if (prm) begin
      pot_ticks[ch] = n[6:0];
      return;
    end
    d = longint'(pot_ticks[ch]) - n;
    if (d > longint'(TICKS_PER_TURN - TICKS_PER_TURN / 2))
      d -= TICKS_PER_TURN;
    else if (d < longint'(TICKS_PER_TURN / 2) - longint'(TICKS_PER_TURN))
      d += TICKS_PER_TURN;
    if (d == 0)
      return;
    pot_ticks[ch] = n[6:0];
    w.enc   = EncOfChan[ch];
    w.delta = d[6:0];
    expected_deltas.push_back(w);
  endfunction

  // Drive one word at the falling edge, idling first as the phase asks, and
  // hold it until the unit takes it. Valid stays high for the next word.
  task automatic send_word(dwpe_pkg::chan_t ch, dwpe_pkg::sample_t a,
                           dwpe_pkg::sample_t b, logic prm);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.wiper_a <= a;
    in_if.wiper_b <= b;
    in_if.prime   <= prm;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
    track_word(ch, a, b, prm);
  endtask

  // Wiper level of a pot at a given phase (4096 per turn): a triangle wave,
  // clipped to the 12-bit range at its peak.
  function automatic dwpe_pkg::sample_t triangle_wiper(int unsigned ph);
    int unsigned p, v;
    p = ph % 4096;
    v = (p < 2048) ? 2 * p : 2 * (4096 - p);
    if (v > 4095)
      v = 4095;
    return v[11:0];
  endfunction

  // Corners of the sample space, both midpoint cases, zero change, priming,
  // ignored channel three and wraps across the zero tick.
  task automatic test_extreme_samples();
    send_word(2'd0, 12'd0,    12'd0,    1'b1);
    send_word(2'd0, 12'd4095, 12'd4095, 1'b0);
    send_word(2'd0, 12'd0,    12'd4095, 1'b0);
    send_word(2'd0, 12'd4095, 12'd0,    1'b0);
    send_word(2'd0, 12'd2048, 12'd2048, 1'b0);
    send_word(2'd0, 12'd2048, 12'd0,    1'b0);
    send_word(2'd0, 12'd2048, 12'd4095, 1'b0);
    send_word(2'd0, 12'd0,    12'd2048, 1'b0);
    send_word(2'd0, 12'd4095, 12'd2048, 1'b0);
    send_word(2'd0, 12'd2047, 12'd2049, 1'b0);
    send_word(2'd0, 12'd2049, 12'd2047, 1'b0);
    send_word(2'd0, 12'd2049, 12'd2047, 1'b0);  // no change: no word out
    send_word(2'd1, 12'd1024, 12'd3072, 1'b1);
    send_word(2'd1, 12'd3072, 12'd1024, 1'b0);
    send_word(2'd2, 12'd0,    12'd0,    1'b0);
    send_word(2'd2, 12'd4095, 12'd4095, 1'b1);
    send_word(2'd3, 12'd4095, 12'd4095, 1'b0);  // dropped channel
    send_word(2'd3, 12'd0,    12'd0,    1'b1);
    send_word(2'd2, 12'd0,    12'd2048, 1'b0);
    send_word(2'd1, 12'd4095, 12'd4095, 1'b0);
    send_word(2'd2, 12'd2048, 12'd2049, 1'b0);
    send_word(2'd0, 12'd2048, 12'd2047, 1'b0);
    send_word(2'd1, 12'd0,    12'd0,    1'b0);
  endtask

  // Turn three pots by random steps after priming each one; mix in re-primes,
  // raw noise samples and words for the missing channel.
  task automatic test_pot_rotation(int unsigned n_words);
    int unsigned     rot [NUM_CHANNELS];
    int unsigned     tracked, pick, step;
    dwpe_pkg::chan_t ch;
    tracked = 0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rot[i] = $urandom_range(4095);
      send_word(dwpe_pkg::chan_t'(i), triangle_wiper(rot[i]), triangle_wiper(rot[i] + 1024),
                1'b1);
    end
    while (tracked < n_words) begin
      pick = $urandom_range(99);
      ch   = dwpe_pkg::chan_t'($urandom_range(NUM_CHANNELS - 1));
      if (pick < 80) begin
        // Mostly small turns either way; now and then a jump anywhere.
        if ($urandom_range(9) == 0)
          step = $urandom_range(4095);
        else
          step = 4096 + $urandom_range(240) - 120;
        rot[ch] = (rot[ch] + step) % 4096;
        send_word(ch, triangle_wiper(rot[ch]), triangle_wiper(rot[ch] + 1024), 1'b0);
        tracked++;
      end else if (pick < 88) begin
        send_word(ch, triangle_wiper(rot[ch]), triangle_wiper(rot[ch] + 1024), 1'b1);
        tracked++;
      end else if (pick < 96) begin
        send_word(ch, dwpe_pkg::sample_t'($urandom_range(4095)),
                  dwpe_pkg::sample_t'($urandom_range(4095)), 1'($urandom_range(1)));
        tracked++;
      end else begin
        send_word(2'd3, dwpe_pkg::sample_t'($urandom_range(4095)),
                  dwpe_pkg::sample_t'($urandom_range(4095)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Receiver side: pick ready at each falling edge per the current stall rate.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic flag_mismatch(string what, delta_word_t want, delta_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected enc %0d delta %0d, got enc %0d delta %0d",
               what, want.enc, $signed(want.delta), got.enc, $signed(got.delta));
  endtask

  // Compare every word the unit hands over with the oldest delta owed.
  always @(posedge clk) begin : check_deltas
    delta_word_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.enc   = out_if.encoder_number;
      got.delta = out_if.delta;
      deltas_seen++;
      if (expected_deltas.size() == 0) begin
        flag_mismatch("no word owed", '0, got);
      end else begin
        want = expected_deltas.pop_front();
        if (got.enc !== want.enc)
          flag_mismatch("encoder number", want, got);
        else if (got.delta !== want.delta)
          flag_mismatch("delta", want, got);
      end
    end
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < dwpe_pkg::MaxChans; i++)
      pot_ticks[i] = '0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.wiper_a = '0;
    in_if.wiper_b = '0;
    in_if.prime   = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Run the directed corners at full rate, then turn the pots under each
    // idling mix: none, sender gaps, receiver stalls, and both together.
    test_extreme_samples();
    test_pot_rotation(RandomWords);
    send_idle_pct  = 61;
    test_pot_rotation(RandomWords);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    test_pot_rotation(RandomWords);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    test_pot_rotation(RandomWords);

    // Drop valid, drain what is owed, then let the pipe run on idle a while.
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_deltas.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);

    if (expected_deltas.size() != 0)
      mismatches++;
    $display("Sent %0d sample words across four idling mixes; %0d delta words checked.",
             words_sent, deltas_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dwpe_pkg.sv
rtl/dwpe_if.sv
rtl/dwpe_angle.sv
rtl/dwpe_track.sv
rtl/dual_wiper_pot_to_encoder_delta_unit.sv
rtl/dwpe_checker.sv
dv/dual_wiper_pot_to_encoder_delta_unit_tb.sv
